>>> rtl/sca_pkg.sv
// shared constants for the separable crossbar allocator
// no dependencies; imported by every rtl file of the block

package sca_pkg;

  // request and grant matrices keep a fixed row stride of eight resources
  localparam int MAT_W      = 64;
  localparam int ROW_STRIDE = 8;

  localparam int DEF_CLIENTS   = 8;
  localparam int DEF_RESOURCES = 8;

  // configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 4;
  localparam int ITER_CFG_W  = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_ITER_COUNT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SLIP_MODE  = CFG_INDEX_W'(1);

  localparam logic [ITER_CFG_W-1:0] ITER_CFG_RESET = ITER_CFG_W'(1);
  localparam logic                  SLIP_RESET     = 1'b1;

  // iteration sequencing
  localparam int MAX_ITERS = 8;
  localparam int ITER_W    = $clog2(MAX_ITERS);

endpackage

>>> rtl/separable_crossbar_allocator_core.sv
// separable input-first crossbar allocator, round-robin arbiters, iSLIP option
// a word runs N iterations in RUN, N = configured iterations (1..8), then waits
// in DONE for the output register; the single iteration unit runs once per cycle of RUN
// in_ready is high only in IDLE; a held output word holds DONE and so stops new input
// reset (synchronous, active low): pointers zero, iterations 1, slip mode on
// depends on sca_pkg, sca_iter, sca_rr_arb

module separable_crossbar_allocator_core
  import sca_pkg::*;
#(
  parameter int CLIENTS   = DEF_CLIENTS,
  parameter int RESOURCES = DEF_RESOURCES
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [MAT_W-1:0]       in_request_matrix,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [MAT_W-1:0]       out_grant_matrix,
  output logic [MAT_W-1:0]       out_remaining_requests,

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CPW = $clog2(RESOURCES);
  localparam int RPW = $clog2(CLIENTS);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                     state_r;
  logic [ITER_W-1:0]              iter_r;
  logic [ITER_W-1:0]              last_r;
  logic [ITER_CFG_W-1:0]          iter_cfg_r;
  logic                           slip_r;
  logic [CLIENTS-1:0][CPW-1:0]    cptr_r;
  logic [RESOURCES-1:0][RPW-1:0]  rptr_r;
  logic [MAT_W-1:0]               req_r;
  logic [MAT_W-1:0]               grant_r;
  logic                           out_valid_r;
  logic [MAT_W-1:0]               out_grant_r;
  logic [MAT_W-1:0]               out_rem_r;

  logic [MAT_W-1:0]               array_mask;
  logic [ITER_W-1:0]              last_nxt;
  logic                           in_fire;
  logic                           out_free;
  logic                           out_load;

  logic [MAT_W-1:0]               req_nxt;
  logic [MAT_W-1:0]               grant_add;
  logic [CLIENTS-1:0][CPW-1:0]    cptr_nxt;
  logic [RESOURCES-1:0][RPW-1:0]  rptr_nxt;

  // bits outside the client x resource array never take part
  always_comb begin
    array_mask = '0;
    for (int i = 0; i < CLIENTS; i++) begin
      for (int j = 0; j < RESOURCES; j++) begin
        array_mask[i*ROW_STRIDE + j] = 1'b1;
      end
    end
  end

  // zero acts as one iteration, anything above eight saturates
  always_comb begin
    if (iter_cfg_r == '0) begin
      last_nxt = '0;
    end else if (iter_cfg_r > ITER_CFG_W'(MAX_ITERS)) begin
      last_nxt = ITER_W'(MAX_ITERS - 1);
    end else begin
      last_nxt = ITER_W'(iter_cfg_r - 1'b1);
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = (state_r == ST_DONE) && out_free;
  assign cfg_ready = 1'b1;

  // one shared iteration unit, reused every cycle of the run
  sca_iter #(
    .CLIENTS   (CLIENTS),
    .RESOURCES (RESOURCES)
  ) u_iter (
    .req              (req_r),
    .client_ptr       (cptr_r),
    .resource_ptr     (rptr_r),
    .slip             (slip_r),
    .req_nxt          (req_nxt),
    .grant_add        (grant_add),
    .client_ptr_nxt   (cptr_nxt),
    .resource_ptr_nxt (rptr_nxt)
  );

  // control state, pointers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      last_r      <= '0;
      iter_cfg_r  <= ITER_CFG_RESET;
      slip_r      <= SLIP_RESET;
      cptr_r      <= '0;
      rptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ITER_COUNT: iter_cfg_r <= cfg_data[ITER_CFG_W-1:0];
          REG_SLIP_MODE:  slip_r     <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            iter_r  <= '0;
            last_r  <= last_nxt;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          cptr_r <= cptr_nxt;
          rptr_r <= rptr_nxt;
          iter_r <= iter_r + 1'b1;
          if (iter_r == last_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // wait here while the previous output word is still held
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // working matrices and output word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r   <= in_request_matrix & array_mask;
      grant_r <= '0;
    end else if (state_r == ST_RUN) begin
      req_r   <= req_nxt;
      grant_r <= grant_r | grant_add;
    end
    if (out_load) begin
      out_grant_r <= grant_r;
      out_rem_r   <= req_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_grant_matrix       = out_grant_r;
  assign out_remaining_requests = out_rem_r;

endmodule

>>> rtl/sca_rr_arb.sv
// round-robin arbiter: first request at or above the pointer, with wrap
// uses sca_pkg for the default width

module sca_rr_arb
  import sca_pkg::*;
#(
  parameter int N = DEF_CLIENTS,
  localparam int W = $clog2(N)
) (
  input  logic [N-1:0] req,
  input  logic [W-1:0] ptr,
  output logic [N-1:0] gnt,
  output logic         found,
  output logic [W-1:0] next_ptr
);

  logic [W-1:0] idx;

  // scan downward so the lowest offset from the pointer wins
  always_comb begin
    logic [W:0] pos;
    pos   = '0;
    idx   = '0;
    found = 1'b0;
    for (int k = N - 1; k >= 0; k--) begin
      pos = {1'b0, ptr} + (W+1)'(k);
      if (pos >= (W+1)'(N)) begin
        pos = pos - (W+1)'(N);
      end
      if (req[pos[W-1:0]]) begin
        idx   = pos[W-1:0];
        found = 1'b1;
      end
    end
  end

  assign gnt      = found ? (N'(1) << idx) : '0;
  assign next_ptr = (idx == W'(N - 1)) ? '0 : idx + 1'b1;

endmodule

>>> rtl/sca_iter.sv
// one request-grant iteration: client arbiters, then resource arbiters
// uses sca_pkg and sca_rr_arb

module sca_iter
  import sca_pkg::*;
#(
  parameter int CLIENTS   = DEF_CLIENTS,
  parameter int RESOURCES = DEF_RESOURCES,
  localparam int CPW = $clog2(RESOURCES),
  localparam int RPW = $clog2(CLIENTS)
) (
  input  logic [MAT_W-1:0]               req,
  input  logic [CLIENTS-1:0][CPW-1:0]    client_ptr,
  input  logic [RESOURCES-1:0][RPW-1:0]  resource_ptr,
  input  logic                           slip,
  output logic [MAT_W-1:0]               req_nxt,
  output logic [MAT_W-1:0]               grant_add,
  output logic [CLIENTS-1:0][CPW-1:0]    client_ptr_nxt,
  output logic [RESOURCES-1:0][RPW-1:0]  resource_ptr_nxt
);

  logic [CLIENTS-1:0][RESOURCES-1:0] client_gnt;
  logic [CLIENTS-1:0]                client_found;
  logic [CLIENTS-1:0][CPW-1:0]       client_next;
  logic [RESOURCES-1:0][CLIENTS-1:0] col_req;
  logic [RESOURCES-1:0][CLIENTS-1:0] res_gnt;
  logic [RESOURCES-1:0]              res_found;
  logic [RESOURCES-1:0][RPW-1:0]     res_next;
  logic [CLIENTS-1:0]                row_clr;

  genvar c, r;

  // client stage
  for (c = 0; c < CLIENTS; c++) begin : g_client
    sca_rr_arb #(.N(RESOURCES)) u_arb (
      .req      (req[c*ROW_STRIDE +: RESOURCES]),
      .ptr      (client_ptr[c]),
      .gnt      (client_gnt[c]),
      .found    (client_found[c]),
      .next_ptr (client_next[c])
    );
  end

  // resource stage
  for (r = 0; r < RESOURCES; r++) begin : g_res
    for (c = 0; c < CLIENTS; c++) begin : g_col
      assign col_req[r][c] = client_gnt[c][r];
    end
    sca_rr_arb #(.N(CLIENTS)) u_arb (
      .req      (col_req[r]),
      .ptr      (resource_ptr[r]),
      .gnt      (res_gnt[r]),
      .found    (res_found[r]),
      .next_ptr (res_next[r])
    );
    assign resource_ptr_nxt[r] = res_found[r] ? res_next[r] : resource_ptr[r];
  end

  // a client wins at most one resource since it picked only one
  always_comb begin
    row_clr = '0;
    for (int i = 0; i < RESOURCES; i++) begin
      row_clr = row_clr | res_gnt[i];
    end
  end

  // with slip a granted client, else any client that picked, moves its pointer one past its pick
  for (c = 0; c < CLIENTS; c++) begin : g_cptr
    assign client_ptr_nxt[c] = (slip ? row_clr[c] : client_found[c]) ?
                               client_next[c] : client_ptr[c];
  end

  always_comb begin
    req_nxt   = '0;
    grant_add = '0;
    for (int i = 0; i < CLIENTS; i++) begin
      for (int j = 0; j < RESOURCES; j++) begin
        grant_add[i*ROW_STRIDE + j] = res_gnt[j][i];
        req_nxt[i*ROW_STRIDE + j]   = req[i*ROW_STRIDE + j] & ~row_clr[i] & ~res_found[j];
      end
    end
  end

endmodule

>>> tb/sv/sca_alloc_check.sv
// allocation checker for separable_crossbar_allocator_core: watches the three channels,
// predicts grant and leftover request matrices, compares every result word in order
// depends on sca_pkg; instantiated beside the block by tb_top

module sca_alloc_check
  import sca_pkg::*;
#(
  parameter int CLIENTS   = DEF_CLIENTS,
  parameter int RESOURCES = DEF_RESOURCES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [MAT_W-1:0]       in_request_matrix,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [MAT_W-1:0]       out_grant_matrix,
  input  logic [MAT_W-1:0]       out_remaining_requests,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [MAT_W-1:0] grant;
    logic [MAT_W-1:0] remaining;
  } alloc_t;

  alloc_t                expected_allocs[$];
  alloc_t                head_alloc;
  logic [2:0]            client_ptr[8];
  logic [2:0]            resource_ptr[8];
  logic [ITER_CFG_W-1:0] iter_cfg;
  logic                  slip_on;
  int                    n_fail;

  // first set bit at or above ptr, with wrap; n when empty
  function automatic int rr_pick(logic [7:0] mask, int ptr, int n);
    int idx;
    for (int k = 0; k < n; k++) begin
      idx = (ptr + k) % n;
      if (mask[idx]) return idx;
    end
    return n;
  endfunction

  function automatic alloc_t allocate(logic [MAT_W-1:0] req_in);
    logic [MAT_W-1:0] req;
    logic [MAT_W-1:0] grant;
    logic [7:0]       col;
    int               iters;
    int               win;
    int               pick[8];
    alloc_t           res;
    req   = '0;
    grant = '0;
    for (int c = 0; c < CLIENTS; c++)
      for (int r = 0; r < RESOURCES; r++)
        req[c*ROW_STRIDE+r] = req_in[c*ROW_STRIDE+r];
    iters = (iter_cfg == 0) ? 1 : (iter_cfg > MAX_ITERS) ? MAX_ITERS : int'(iter_cfg);
    for (int it = 0; it < iters; it++) begin
      // client stage
      for (int c = 0; c < CLIENTS; c++) begin
        pick[c] = rr_pick(req[c*ROW_STRIDE +: 8], client_ptr[c], RESOURCES);
        if (!slip_on && pick[c] < RESOURCES) client_ptr[c] = 3'((pick[c] + 1) % RESOURCES);
      end
      // resource stage
      for (int r = 0; r < RESOURCES; r++) begin
        col = '0;
        for (int c = 0; c < CLIENTS; c++)
          if (pick[c] == r) col[c] = 1'b1;
        win = rr_pick(col, resource_ptr[r], CLIENTS);
        if (win < CLIENTS) begin
          grant[win*ROW_STRIDE+r] = 1'b1;
          for (int k = 0; k < RESOURCES; k++) req[win*ROW_STRIDE+k] = 1'b0;
          for (int k = 0; k < CLIENTS; k++) req[k*ROW_STRIDE+r] = 1'b0;
          resource_ptr[r] = 3'((win + 1) % CLIENTS);
          if (slip_on) client_ptr[win] = 3'((r + 1) % RESOURCES);
        end
      end
    end
    res.grant     = grant;
    res.remaining = req;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        client_ptr[i]   = '0;
        resource_ptr[i] = '0;
      end
      iter_cfg = ITER_CFG_RESET;
      slip_on  = SLIP_RESET;
      expected_allocs.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ITER_COUNT) iter_cfg = cfg_data[ITER_CFG_W-1:0];
        else if (cfg_index == REG_SLIP_MODE) slip_on = cfg_data[0];
      end
      if (in_valid && in_ready) expected_allocs.push_back(allocate(in_request_matrix));
      if (out_valid && out_ready) begin
        if (expected_allocs.size() == 0) begin
          $error("result word with no allocation pending: grant %h remaining %h",
                 out_grant_matrix, out_remaining_requests);
          n_fail++;
        end else begin
          head_alloc = expected_allocs.pop_front();
          if (out_grant_matrix !== head_alloc.grant) begin
            $error("grant_matrix expected %h actual %h", head_alloc.grant, out_grant_matrix);
            n_fail++;
          end
          if (out_remaining_requests !== head_alloc.remaining) begin
            $error("remaining_requests expected %h actual %h",
                   head_alloc.remaining, out_remaining_requests);
            n_fail++;
          end
        end
      end
      outstanding <= expected_allocs.size();
      fail_count  <= n_fail;
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// top of the allocator testbench: clock, reset, request and register stimulus, verdict
// depends on sca_pkg, separable_crossbar_allocator_core and sca_alloc_check

module tb_top;
  import sca_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no handshake on any channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // drain margin after the last result, sized from MAX_ITERS
  localparam int TAIL_CYCLES    = 2 * (MAX_ITERS + 2);
  localparam int PHASES         = 8;
  localparam int WORDS_PER_PHASE = 185;
  // an index past the last register, writes to it must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = '1;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [MAT_W-1:0]       in_request_matrix = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [MAT_W-1:0]       out_grant_matrix;
  logic [MAT_W-1:0]       out_remaining_requests;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  bit calm = 1'b0;  // set for the final phase: no stalls on either side

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  separable_crossbar_allocator_core i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_request_matrix      (in_request_matrix),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_grant_matrix       (out_grant_matrix),
    .out_remaining_requests (out_remaining_requests),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  sca_alloc_check i_alloc_check (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_request_matrix      (in_request_matrix),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_grant_matrix       (out_grant_matrix),
    .out_remaining_requests (out_remaining_requests),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .fail_count             (fail_count),
    .outstanding            (outstanding)
  );

  // watchdog: any accepted word on any channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side back-pressure: ready bursts, then maybe a stall burst; always ready once calm
  initial begin
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        if ($urandom_range(0, 1) == 1) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
      end
    end
  end

  // request matrices of several shapes, so that contention and leftovers both show up
  function automatic logic [MAT_W-1:0] random_requests();
    logic [MAT_W-1:0] m;
    int               hot;
    m = '0;
    case ($urandom_range(0, 5))
      0: m = {$urandom, $urandom};
      1: m = {$urandom, $urandom} & {$urandom, $urandom};
      2: m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      3: m = {$urandom, $urandom} | {$urandom, $urandom};
      4: begin
        // each client wants at most one resource
        for (int c = 0; c < DEF_CLIENTS; c++)
          if ($urandom_range(0, 3) != 0) m[c*ROW_STRIDE + $urandom_range(0, 7)] = 1'b1;
      end
      default: begin
        // hot spot: many clients fight for one resource, a little noise elsewhere
        hot = $urandom_range(0, 7);
        for (int c = 0; c < DEF_CLIENTS; c++)
          if ($urandom_range(0, 1) == 1) m[c*ROW_STRIDE + hot] = 1'b1;
        m |= {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      end
    endcase
    return m;
  endfunction

  // present one request word, optionally after an idle gap; valid stays up on return
  task automatic send_requests(input logic [MAT_W-1:0] m, input int gap_odds);
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_request_matrix <= m;
    do @(posedge clk); while (!in_ready);
  endtask

  // register write; valid stays up so back-to-back writes never toggle it in one step
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // every word returned; the block is idle again since each word yields exactly one result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  logic [MAT_W-1:0] directed_words[15] = '{
    64'h0000_0000_0000_0000,   // nothing requested
    64'hFFFF_FFFF_FFFF_FFFF,   // everybody wants everything
    64'h0000_0000_0000_0001,   // lowest corner
    64'h8000_0000_0000_0000,   // highest corner
    64'h8040_2010_0804_0201,   // diagonal, no conflicts
    64'h0102_0408_1020_4080,   // anti-diagonal
    64'h0101_0101_0101_0101,   // all clients on resource 0
    64'h8080_8080_8080_8080,   // all clients on the last resource
    64'h0000_0000_0000_00FF,   // one client wants all resources
    64'hFF00_0000_0000_0000,   // last client wants all resources
    64'hAA55_AA55_AA55_AA55,
    64'h55AA_55AA_55AA_55AA,
    64'hFFFF_FFFF_FFFF_FFFF,   // full again, pointers have moved
    64'h0F0F_0F0F_F0F0_F0F0,
    64'hFFFF_FFFF_FFFF_FFFF
  };

  int iter_plan[PHASES] = '{8, 4, 0, 15, 2, 3, 1, 5};
  bit slip_plan[PHASES] = '{0, 1, 1, 0, 1, 0, 0, 1};

  initial begin
    int gap_odds;
    // synchronous reset, applied once at the start
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed words under the reset settings: one iteration, slip mode on
    foreach (directed_words[i]) send_requests(directed_words[i], 4);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      // registers change only while nothing is in flight
      write_reg(REG_ITER_COUNT, CFG_DATA_W'(iter_plan[p]));
      write_reg(REG_SLIP_MODE, CFG_DATA_W'(($urandom_range(0, 7) << 1) | slip_plan[p]));
      if (p % 2 == 0) begin
        // writes to indexes beyond the register list must change nothing
        write_reg(CFG_INDEX_W'($urandom_range(REG_SLIP_MODE + 1, REG_UNUSED_TOP)),
                  CFG_DATA_W'($urandom));
        write_reg(REG_UNUSED_TOP, '1);
      end
      cfg_valid <= 1'b0;

      // final phase runs without any idling; others alternate heavy, light and none
      if (p == PHASES - 1) calm = 1'b1;
      gap_odds = (p % 3 == 0) ? 3 : (p % 3 == 1) ? 10 : 0;
      repeat (WORDS_PER_PHASE) send_requests(random_requests(), gap_odds);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
